[src/mtsp_pkg.sv]
// shared constants, codes and types of the trapezoid segment planner
`timescale 1ns / 1ps
package mtsp_pkg;
    localparam int COORD_BITS = 21;
    localparam int TIME_BITS  = 24;
    localparam int DIST_BITS  = COORD_BITS + 1;
    localparam int ACCEL_BITS = 20;
    localparam int SPEED_BITS = 16;
    localparam int ALU_W      = 84;
    localparam int CNT_W      = 7;

    localparam logic [1:0] KIND_MOVE = 2'd2;

    localparam logic CFG_MAX_ACCEL = 1'b0;
    localparam logic CFG_MAX_SPEED = 1'b1;

    localparam logic [ACCEL_BITS-1:0] ACCEL_RESET = 20'd10000;
    localparam logic [SPEED_BITS-1:0] SPEED_RESET = 16'd500;

    typedef logic [1:0] t_alu_op;
    localparam t_alu_op OP_MUL  = 2'd0;
    localparam t_alu_op OP_DIV  = 2'd1;
    localparam t_alu_op OP_SQRT = 2'd2;

    typedef struct packed {
        logic             start;
        t_alu_op          op;
        logic [CNT_W-1:0] steps;
    } t_alu_req;
endpackage

[src/mtsp_in_if.sv]
// command request channel
`timescale 1ns / 1ps
interface mtsp_in_if import mtsp_pkg::*; ();
    logic                         valid;
    logic                         ready;
    logic [1:0]                   kind;
    logic [6:0]                   laser_power;
    logic signed [COORD_BITS-1:0] target_x;
    logic signed [COORD_BITS-1:0] target_y;
    logic [15:0]                  source_line;
    logic [15:0]                  wait_ms;

    modport source (output valid, kind, laser_power, target_x, target_y, source_line,
                    wait_ms, input ready);
    modport sink (input valid, kind, laser_power, target_x, target_y, source_line,
                  wait_ms, output ready);
endinterface

[src/mtsp_out_if.sv]
// segment request channel
`timescale 1ns / 1ps
interface mtsp_out_if import mtsp_pkg::*; ();
    logic                         valid;
    logic                         ready;
    logic [1:0]                   out_kind;
    logic [6:0]                   out_power;
    logic signed [COORD_BITS-1:0] point_x;
    logic signed [COORD_BITS-1:0] point_y;
    logic [15:0]                  out_line;
    logic [TIME_BITS-1:0]         duration_ms;
    logic                         last;

    modport source (output valid, out_kind, out_power, point_x, point_y, out_line,
                    duration_ms, last, input ready);
    modport sink (input valid, out_kind, out_power, point_x, point_y, out_line,
                  duration_ms, last, output ready);
endinterface

[src/move_trapezoid_segment_planner_unit.sv]
// trapezoid segment planner top level: sequencer, move state and result register
//  channel | dir | fields
//  i_cmd   | in  | kind, laser_power, target_x, target_y, source_line, wait_ms
//  o_seg   | out | out_kind, out_power, point_x, point_y, out_line, duration_ms, last
//  i_cfg_* | in  | write enable, register index, data
// one command at a time; the time from the accepting cycle back to ready is set by the
// bit-serial arithmetic unit (one multiplier bit, one quotient bit or one root bit per
// cycle) and, for each request emitted, by when the output is free.
// reset is synchronous; it restores the registers and the origin point.
// a stalled output holds the sequencer in its emit step; no request is ever dropped.
`timescale 1ns / 1ps
module move_trapezoid_segment_planner_unit import mtsp_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    mtsp_in_if.sink               i_cmd,
    mtsp_out_if.source            o_seg,
    input  logic                  i_cfg_we,
    input  logic                  i_cfg_idx,
    input  logic [ACCEL_BITS-1:0] i_cfg_data
);
    localparam logic [4:0] S_IDLE = 5'd0;
    localparam logic [4:0] S_MXX  = 5'd1;
    localparam logic [4:0] S_MYY  = 5'd2;
    localparam logic [4:0] S_SQ   = 5'd3;
    localparam logic [4:0] S_MW   = 5'd4;
    localparam logic [4:0] S_MV2  = 5'd5;
    localparam logic [4:0] S_DACC = 5'd6;
    localparam logic [4:0] S_MVA  = 5'd7;
    localparam logic [4:0] S_MNUM = 5'd8;
    localparam logic [4:0] S_DCR  = 5'd9;
    localparam logic [4:0] S_M1X  = 5'd10;
    localparam logic [4:0] S_D1X  = 5'd11;
    localparam logic [4:0] S_M1Y  = 5'd12;
    localparam logic [4:0] S_D1Y  = 5'd13;
    localparam logic [4:0] S_M2X  = 5'd14;
    localparam logic [4:0] S_D2X  = 5'd15;
    localparam logic [4:0] S_M2Y  = 5'd16;
    localparam logic [4:0] S_D2Y  = 5'd17;
    localparam logic [4:0] S_MH   = 5'd18;
    localparam logic [4:0] S_DH   = 5'd19;
    localparam logic [4:0] S_SQH  = 5'd20;
    localparam logic [4:0] S_DHX  = 5'd21;
    localparam logic [4:0] S_DHY  = 5'd22;
    localparam logic [4:0] S_E0   = 5'd23;
    localparam logic [4:0] S_E1   = 5'd24;
    localparam logic [4:0] S_E2   = 5'd25;
    localparam logic [4:0] S_EP   = 5'd26;

    localparam logic [TIME_BITS-1:0] TIME_MAX = {TIME_BITS{1'b1}};

    logic [4:0]                   r_state;
    logic                         r_go;
    logic                         r_full;
    logic [ACCEL_BITS-1:0]        r_acc_cfg;
    logic [SPEED_BITS-1:0]        r_spd_cfg;
    logic signed [COORD_BITS-1:0] r_px, r_py;

    logic [1:0]                   r_kind;
    logic [6:0]                   r_power;
    logic signed [COORD_BITS-1:0] r_tx, r_ty;
    logic [15:0]                  r_line, r_wait;
    logic [DIST_BITS-1:0]         r_dx, r_dy;
    logic [43:0]                  r_sq;
    logic [38:0]                  r_ef;
    logic [59:0]                  r_w;
    logic [47:0]                  r_v2;
    logic [35:0]                  r_va;
    logic [ALU_W-1:0]             r_tmp;
    logic [TIME_BITS-1:0]         r_t0, r_t1;
    logic [COORD_BITS-1:0]        r_x1, r_y1, r_x2, r_y2;

    logic                         r_ov;
    logic [1:0]                   r_o_kind;
    logic [6:0]                   r_o_power;
    logic [COORD_BITS-1:0]        r_o_x, r_o_y;
    logic [15:0]                  r_o_line;
    logic [TIME_BITS-1:0]         r_o_dur;
    logic                         r_o_last;

    t_alu_req                     w_req;
    logic [ALU_W-1:0]             w_alu_a, w_alu_b, w_res, w_rem;
    logic                         w_done, w_exact, w_diag, w_calc, w_slot, w_accept;
    logic [ACCEL_BITS-1:0]        w_a;
    logic [SPEED_BITS-1:0]        w_v;
    logic [DIST_BITS-1:0]         w_ax, w_ay;
    logic [47:0]                  w_v2_new;
    logic [60:0]                  w_tot;

    function automatic logic [COORD_BITS-1:0] split_pt(
        input logic signed [COORD_BITS-1:0] p,
        input logic                         neg,
        input logic [DIST_BITS-1:0]         q,
        input logic                         exact
    );
        logic signed [COORD_BITS+2:0] b;
        if (!neg) begin
            b = (COORD_BITS+3)'(p) + $signed({2'b00, q});
            if (!exact && b[COORD_BITS+2]) b = b + (COORD_BITS+3)'(1);
        end else begin
            b = (COORD_BITS+3)'(p) - $signed({2'b00, q});
            if (!exact && !b[COORD_BITS+2] && b != '0) b = b - (COORD_BITS+3)'(1);
        end
        return b[COORD_BITS-1:0];
    endfunction

    function automatic logic [TIME_BITS-1:0] sat_time(input logic [ALU_W-1:0] q);
        return q[TIME_BITS] ? TIME_MAX : q[TIME_BITS-1:0];
    endfunction

    assign w_a      = (r_acc_cfg == '0) ? ACCEL_BITS'(1) : r_acc_cfg;
    assign w_v      = (r_spd_cfg == '0) ? SPEED_BITS'(1) : r_spd_cfg;
    assign w_ax     = r_dx[DIST_BITS-1] ? -r_dx : r_dx;
    assign w_ay     = r_dy[DIST_BITS-1] ? -r_dy : r_dy;
    assign w_diag   = (r_dx != '0) && (r_dy != '0);
    assign w_exact  = (w_rem == '0);
    assign w_v2_new = {w_res[31:0], 16'b0};
    assign w_tot    = 61'(r_w) + 61'(r_v2);
    assign w_calc   = r_state inside {[S_MXX:S_DHY]};
    assign w_slot   = !r_ov || o_seg.ready;
    assign w_accept = i_cmd.valid && i_cmd.ready;

    always_comb begin
        w_req.start = w_calc && !r_go;
        w_req.op    = OP_MUL;
        w_req.steps = '0;
        w_alu_a     = '0;
        w_alu_b     = '0;
        case (r_state)
            S_MXX: begin
                w_alu_a = ALU_W'(w_ax); w_alu_b = ALU_W'(w_ax); w_req.steps = CNT_W'(22);
            end
            S_MYY: begin
                w_alu_a = ALU_W'(w_ay); w_alu_b = ALU_W'(w_ay); w_req.steps = CNT_W'(22);
            end
            S_SQ: begin
                w_req.op = OP_SQRT; w_req.steps = CNT_W'(39);
                w_alu_a = w_diag ? {r_sq, 40'b0} >> 1 : {r_sq, 40'b0} >> 2;
            end
            S_MW: begin
                w_alu_a = ALU_W'(r_ef); w_alu_b = ALU_W'(w_a); w_req.steps = CNT_W'(20);
            end
            S_MV2: begin
                w_alu_a = ALU_W'(w_v); w_alu_b = ALU_W'(w_v); w_req.steps = CNT_W'(16);
            end
            S_DACC: begin
                w_req.op = OP_DIV; w_req.steps = CNT_W'(25);
                w_alu_a = ALU_W'({w_v, 10'b0}) - ALU_W'({w_v, 4'b0}) - ALU_W'({w_v, 3'b0});
                w_alu_b = ALU_W'({w_a, 24'b0});
            end
            S_MVA: begin
                w_alu_a = ALU_W'(w_a); w_alu_b = ALU_W'(w_v); w_req.steps = CNT_W'(16);
            end
            S_MNUM: begin
                w_alu_a = ALU_W'(r_w - 60'(r_v2)); w_alu_b = ALU_W'(1000);
                w_req.steps = CNT_W'(10);
            end
            S_DCR: begin
                w_req.op = OP_DIV; w_req.steps = CNT_W'(25);
                w_alu_a = r_tmp; w_alu_b = ALU_W'({r_va, 40'b0});
            end
            S_M1X: begin
                w_alu_a = ALU_W'(r_v2); w_alu_b = ALU_W'(w_ax); w_req.steps = CNT_W'(22);
            end
            S_M1Y: begin
                w_alu_a = ALU_W'(r_v2); w_alu_b = ALU_W'(w_ay); w_req.steps = CNT_W'(22);
            end
            S_M2X: begin
                w_alu_a = ALU_W'(r_w); w_alu_b = ALU_W'(w_ax); w_req.steps = CNT_W'(22);
            end
            S_M2Y: begin
                w_alu_a = ALU_W'(r_w); w_alu_b = ALU_W'(w_ay); w_req.steps = CNT_W'(22);
            end
            S_D1X, S_D1Y, S_D2X, S_D2Y: begin
                w_req.op = OP_DIV; w_req.steps = CNT_W'(22);
                w_alu_a = r_tmp; w_alu_b = ALU_W'({w_tot, 21'b0});
            end
            S_MH: begin
                w_alu_a = ALU_W'(r_ef); w_alu_b = ALU_W'(1000000); w_req.steps = CNT_W'(20);
            end
            S_DH: begin
                w_req.op = OP_DIV; w_req.steps = CNT_W'(43);
                w_alu_a = r_tmp >> 16; w_alu_b = ALU_W'({w_a, 42'b0});
            end
            S_SQH: begin
                w_req.op = OP_SQRT; w_req.steps = CNT_W'(22);
                w_alu_a = {r_tmp[43:0], 40'b0};
            end
            S_DHX: begin
                w_req.op = OP_DIV; w_req.steps = CNT_W'(22);
                w_alu_a = ALU_W'(w_ax); w_alu_b = ALU_W'({2'b10, 21'b0});
            end
            S_DHY: begin
                w_req.op = OP_DIV; w_req.steps = CNT_W'(22);
                w_alu_a = ALU_W'(w_ay); w_alu_b = ALU_W'({2'b10, 21'b0});
            end
            default: ;
        endcase
    end

    mtsp_alu u_alu (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_req),
        .i_a     (w_alu_a),
        .i_b     (w_alu_b),
        .o_done  (w_done),
        .o_res   (w_res),
        .o_rem   (w_rem)
    );

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_go      <= 1'b0;
            r_ov      <= 1'b0;
            r_acc_cfg <= ACCEL_RESET;
            r_spd_cfg <= SPEED_RESET;
            r_px      <= '0;
            r_py      <= '0;
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_idx == CFG_MAX_ACCEL) r_acc_cfg <= i_cfg_data;
                else r_spd_cfg <= i_cfg_data[SPEED_BITS-1:0];
            end
            if (r_ov && o_seg.ready) r_ov <= 1'b0;
            if (w_req.start) r_go <= 1'b1;
            if (w_done) r_go <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (w_accept) r_state <= (i_cmd.kind == KIND_MOVE) ? S_MXX : S_EP;
                end
                S_MV2: begin
                    if (w_done) r_state <= (r_w >= 60'(w_v2_new)) ? S_DACC : S_MH;
                end
                S_D2Y, S_DHY: begin
                    if (w_done) begin
                        r_state <= S_E0;
                        r_px    <= r_tx;
                        r_py    <= r_ty;
                    end
                end
                S_E0: begin
                    if (w_slot) begin
                        r_ov <= 1'b1; r_state <= S_E1;
                    end
                end
                S_E1: begin
                    if (w_slot) begin
                        r_ov <= 1'b1; r_state <= r_full ? S_E2 : S_IDLE;
                    end
                end
                S_E2, S_EP: begin
                    if (w_slot) begin
                        r_ov <= 1'b1; r_state <= S_IDLE;
                    end
                end
                default: begin
                    if (w_done) r_state <= (r_state == S_SQH) ? S_DHX : r_state + 5'd1;
                end
            endcase
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_kind  <= i_cmd.kind;
            r_power <= i_cmd.laser_power;
            r_tx    <= i_cmd.target_x;
            r_ty    <= i_cmd.target_y;
            r_line  <= i_cmd.source_line;
            r_wait  <= i_cmd.wait_ms;
            r_dx    <= DIST_BITS'(i_cmd.target_x) - DIST_BITS'(r_px);
            r_dy    <= DIST_BITS'(i_cmd.target_y) - DIST_BITS'(r_py);
        end
        if (w_done) begin
            case (r_state)
                S_MXX:  r_sq <= w_res[43:0];
                S_MYY:  r_sq <= r_sq + w_res[43:0];
                S_SQ:   r_ef <= w_res[38:0];
                S_MW:   r_w <= w_res[59:0];
                S_MV2: begin
                    r_v2   <= w_v2_new;
                    r_full <= r_w >= 60'(w_v2_new);
                end
                S_DACC: r_t0 <= sat_time(w_res);
                S_MVA:  r_va <= w_res[35:0];
                S_DCR:  r_t1 <= sat_time(w_res);
                S_D1X, S_DHX: r_x1 <= split_pt(r_px, r_dx[DIST_BITS-1], w_res[DIST_BITS-1:0],
                                               w_exact);
                S_D1Y, S_DHY: r_y1 <= split_pt(r_py, r_dy[DIST_BITS-1], w_res[DIST_BITS-1:0],
                                               w_exact);
                S_D2X:  r_x2 <= split_pt(r_px, r_dx[DIST_BITS-1], w_res[DIST_BITS-1:0],
                                         w_exact);
                S_D2Y:  r_y2 <= split_pt(r_py, r_dy[DIST_BITS-1], w_res[DIST_BITS-1:0],
                                         w_exact);
                S_SQH:  r_t0 <= TIME_BITS'(w_res[21:0]);
                default: r_tmp <= w_res;
            endcase
        end
        if (w_slot) begin
            r_o_power <= r_power;
            r_o_line  <= r_line;
            case (r_state)
                S_E0: begin
                    r_o_kind <= KIND_MOVE;
                    r_o_x <= r_x1; r_o_y <= r_y1; r_o_dur <= r_t0; r_o_last <= 1'b0;
                end
                S_E1: begin
                    r_o_kind <= KIND_MOVE;
                    r_o_x    <= r_full ? r_x2 : r_tx;
                    r_o_y    <= r_full ? r_y2 : r_ty;
                    r_o_dur  <= r_full ? r_t1 : r_t0;
                    r_o_last <= !r_full;
                end
                S_E2: begin
                    r_o_kind <= KIND_MOVE;
                    r_o_x <= r_tx; r_o_y <= r_ty; r_o_dur <= r_t0; r_o_last <= 1'b1;
                end
                S_EP: begin
                    r_o_kind <= r_kind;
                    r_o_x    <= r_tx;
                    r_o_y    <= r_ty;
                    r_o_dur  <= TIME_BITS'(r_wait);
                    r_o_last <= 1'b1;
                end
                default: ;
            endcase
        end
    end

    assign i_cmd.ready       = (r_state == S_IDLE);
    assign o_seg.valid       = r_ov;
    assign o_seg.out_kind    = r_o_kind;
    assign o_seg.out_power   = r_o_power;
    assign o_seg.point_x     = r_o_x;
    assign o_seg.point_y     = r_o_y;
    assign o_seg.out_line    = r_o_line;
    assign o_seg.duration_ms = r_o_dur;
    assign o_seg.last        = r_o_last;

`ifndef SYNTHESIS
    a_move_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && i_cmd.kind == KIND_MOVE) |=> (r_state == S_MXX))
        else $error("move did not start arithmetic");
    a_pass_emits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && i_cmd.kind != KIND_MOVE) |=> (r_state == S_EP))
        else $error("pass-through command not routed to emit");
    a_prev_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |=> ($stable(r_px) && $stable(r_py)))
        else $error("previous point changed while idle");
    a_done_in_calc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_done |-> (w_calc && r_go))
        else $error("arithmetic finished outside a compute step");
`endif
endmodule

[src/mtsp_alu.sv]
// bit-serial multiply, shifting-divisor divide and two-bit-per-step square root
`timescale 1ns / 1ps
module mtsp_alu import mtsp_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_alu_req         i_req,
    input  logic [ALU_W-1:0] i_a,
    input  logic [ALU_W-1:0] i_b,
    output logic             o_done,
    output logic [ALU_W-1:0] o_res,
    output logic [ALU_W-1:0] o_rem
);
    logic             r_busy;
    logic             r_done;
    t_alu_op          r_op;
    logic [CNT_W-1:0] r_cnt;
    logic [ALU_W-1:0] r_r, r_a, r_b, r_q;
    logic [ALU_W-1:0] n_r, n_a, n_b, n_q;
    logic [ALU_W-1:0] w_rem2, w_trial;
    logic             w_ge;

    always_comb begin
        n_r     = r_r;
        n_a     = r_a;
        n_b     = r_b;
        n_q     = r_q;
        w_rem2  = {r_r[ALU_W-3:0], r_a[ALU_W-1 -: 2]};
        w_trial = {r_q[ALU_W-3:0], 2'b01};
        w_ge    = 1'b0;
        case (r_op)
            OP_MUL: begin
                n_r = r_b[0] ? r_r + r_a : r_r;
                n_a = {r_a[ALU_W-2:0], 1'b0};
                n_b = {1'b0, r_b[ALU_W-1:1]};
            end
            OP_DIV: begin
                w_ge = r_r >= r_a;
                n_r  = w_ge ? r_r - r_a : r_r;
                n_q  = {r_q[ALU_W-2:0], w_ge};
                n_a  = {1'b0, r_a[ALU_W-1:1]};
            end
            OP_SQRT: begin
                w_ge = w_rem2 >= w_trial;
                n_r  = w_ge ? w_rem2 - w_trial : w_rem2;
                n_q  = {r_q[ALU_W-2:0], w_ge};
                n_a  = {r_a[ALU_W-3:0], 2'b00};
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
            end else if (r_busy && r_cnt == CNT_W'(1)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_op  <= i_req.op;
            r_cnt <= i_req.steps;
            r_r   <= (i_req.op == OP_DIV) ? i_a : '0;
            r_a   <= (i_req.op == OP_DIV) ? i_b : i_a;
            r_b   <= i_b;
            r_q   <= '0;
        end else if (r_busy) begin
            r_cnt <= r_cnt - CNT_W'(1);
            r_r   <= n_r;
            r_a   <= n_a;
            r_b   <= n_b;
            r_q   <= n_q;
        end
    end

    assign o_done = r_done;
    assign o_res  = (r_op == OP_MUL) ? r_r : r_q;
    assign o_rem  = r_r;
endmodule

[tb/move_trapezoid_segment_planner_unit_tb_if.sv]
// configuration write bundle driven by the testbench
`timescale 1ns / 1ps
interface mtsp_cfg_if import mtsp_pkg::*; ();
    logic                  we;
    logic                  idx;
    logic [ACCEL_BITS-1:0] data;
endinterface

[tb/move_trapezoid_segment_planner_unit_tb.sv]
// self-checking testbench of the trapezoid segment planner with a bit-exact predictor
`timescale 1ns / 1ps
module move_trapezoid_segment_planner_unit_tb;
    import mtsp_pkg::*;

    localparam int IDLE_LIMIT = 20000;
    localparam logic [1:0] KIND_HOME  = 2'd0;
    localparam logic [1:0] KIND_POWER = 2'd1;
    localparam logic [1:0] KIND_OTHER = 2'd3;
    localparam logic [127:0] TIME_TOP = (128'd1 << TIME_BITS) - 1;

    typedef struct {
        logic [1:0]                   kind;
        logic [6:0]                   power;
        logic signed [COORD_BITS-1:0] tx;
        logic signed [COORD_BITS-1:0] ty;
        logic [15:0]                  line;
        logic [15:0]                  wait_ms;
        bit                           drain;
    } t_cmd;

    typedef struct {
        logic [1:0]                   kind;
        logic [6:0]                   power;
        logic signed [COORD_BITS-1:0] px;
        logic signed [COORD_BITS-1:0] py;
        logic [15:0]                  line;
        logic [TIME_BITS-1:0]         dur;
        logic                         last;
    } t_seg;

    logic i_clk = 0;
    logic i_rst_n = 0;

    mtsp_in_if  cmd ();
    mtsp_out_if seg ();
    mtsp_cfg_if cfg ();

    move_trapezoid_segment_planner_unit uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cmd(cmd), .o_seg(seg),
        .i_cfg_we(cfg.we), .i_cfg_idx(cfg.idx), .i_cfg_data(cfg.data)
    );

    t_cmd pending_cmds[$];
    t_seg expected_segs[$];
    t_cmd cur_cmd;
    logic [ACCEL_BITS-1:0] model_accel = ACCEL_RESET;
    logic [SPEED_BITS-1:0] model_speed = SPEED_RESET;
    longint model_px = 0, model_py = 0;
    longint gen_px = 0, gen_py = 0;
    int errors = 0, sent = 0, got = 0, idle_cycles = 0, hold_left = 0;
    bit hold_done = 0;

    initial begin
        cmd.valid = 0; cmd.kind = '0; cmd.laser_power = '0; cmd.target_x = '0;
        cmd.target_y = '0; cmd.source_line = '0; cmd.wait_ms = '0; seg.ready = 0;
        cfg.we = 0; cfg.idx = 0; cfg.data = '0;
        forever #1 i_clk = ~i_clk;
    end

    function automatic logic [63:0] root_of(logic [127:0] x);
        logic [63:0] res = 0, cand;
        for (int b = 63; b >= 0; b--) begin
            cand = res | (64'd1 << b);
            if ({64'd0, cand} * {64'd0, cand} <= x) res = cand;
        end
        return res;
    endfunction

    function automatic logic [TIME_BITS-1:0] clip_time(logic [127:0] x);
        return (x > TIME_TOP) ? TIME_TOP[TIME_BITS-1:0] : x[TIME_BITS-1:0];
    endfunction

    function automatic logic signed [COORD_BITS-1:0] split_at(longint p, longint d,
                                                              logic [127:0] num, den);
        logic [127:0] prod, q, r;
        longint mag, base;
        mag = d < 0 ? -d : d;
        prod = num * mag;
        q = prod / den;
        r = prod % den;
        if (d >= 0) begin
            base = p + longint'(q);
            if (r != 0 && base < 0) base += 1;
        end else begin
            base = p - longint'(q);
            if (r != 0 && base > 0) base -= 1;
        end
        return base[COORD_BITS-1:0];
    endfunction

    function automatic void plan_segments(t_cmd c);
        t_seg s;
        longint dx, dy, tx, ty;
        logic [127:0] a, v, ax, ay, q, ef, w, v2, tot, x;
        logic [TIME_BITS-1:0] acc, half;
        s.kind = c.kind; s.power = c.power; s.line = c.line;
        if (c.kind != KIND_MOVE) begin
            s.px = c.tx; s.py = c.ty; s.dur = c.wait_ms; s.last = 1;
            expected_segs.push_back(s);
            return;
        end
        tx = c.tx; ty = c.ty;
        a = model_accel == 0 ? 1 : model_accel;
        v = model_speed == 0 ? 1 : model_speed;
        dx = tx - model_px; dy = ty - model_py;
        ax = dx < 0 ? -dx : dx; ay = dy < 0 ? -dy : dy;
        q = (ax * ax + ay * ay) << ((dx != 0 && dy != 0) ? 33 : 32);
        ef = root_of(q);
        w = ef * a;
        v2 = (v * v) << 16;
        if (w >= v2) begin
            acc = clip_time(1000 * v / a);
            tot = v2 + w;
            s.px = split_at(model_px, dx, v2, tot); s.py = split_at(model_py, dy, v2, tot);
            s.dur = acc; s.last = 0; expected_segs.push_back(s);
            s.px = split_at(model_px, dx, w, tot); s.py = split_at(model_py, dy, w, tot);
            s.dur = clip_time(((w - v2) * 1000) / ((v * a) << 16));
            expected_segs.push_back(s);
            s.px = c.tx; s.py = c.ty; s.dur = acc; s.last = 1; expected_segs.push_back(s);
        end else begin
            x = ((ef * 1000000) << 16) / a;
            half = clip_time(root_of(x) >> 16);
            s.px = split_at(model_px, dx, 1, 2); s.py = split_at(model_py, dy, 1, 2);
            s.dur = half; s.last = 0; expected_segs.push_back(s);
            s.px = c.tx; s.py = c.ty; s.last = 1; expected_segs.push_back(s);
        end
        model_px = tx; model_py = ty;
    endfunction

    // driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            cmd.valid <= 0;
        end else begin
            if (cmd.valid && cmd.ready) begin
                plan_segments(cur_cmd);
                sent++;
            end
            if (!cmd.valid || cmd.ready) begin
                if (pending_cmds.size() == 0 ||
                    (pending_cmds[0].drain && expected_segs.size() != 0)) begin
                    cmd.valid <= 0;
                end else if (!(sent >= 180 && sent < 230) && $urandom_range(99) < 31) begin
                    cmd.valid <= 0;
                end else begin
                    cur_cmd = pending_cmds.pop_front();
                    cmd.valid <= 1;
                    cmd.kind <= cur_cmd.kind;
                    cmd.laser_power <= cur_cmd.power;
                    cmd.target_x <= cur_cmd.tx;
                    cmd.target_y <= cur_cmd.ty;
                    cmd.source_line <= cur_cmd.line;
                    cmd.wait_ms <= cur_cmd.wait_ms;
                end
            end
        end
    end

    // monitor
    always @(posedge i_clk) begin
        t_seg e;
        if (!i_rst_n) begin
            seg.ready <= 0;
        end else begin
            if (seg.valid && seg.ready) begin
                got++;
                if (expected_segs.size() == 0) begin
                    $display("%0t: unexpected segment kind=%0d x=%0d y=%0d dur=%0d", $time,
                             seg.out_kind, seg.point_x, seg.point_y, seg.duration_ms);
                    errors++;
                end else begin
                    e = expected_segs.pop_front();
                    if (seg.out_kind !== e.kind || seg.out_power !== e.power ||
                        seg.point_x !== e.px || seg.point_y !== e.py ||
                        seg.out_line !== e.line || seg.duration_ms !== e.dur ||
                        seg.last !== e.last) begin
                        $display({"%0t: mismatch expected k=%0d p=%0d x=%0d y=%0d",
                                  " l=%0d d=%0d last=%0d"},
                                 $time, e.kind, e.power, e.px, e.py, e.line, e.dur, e.last);
                        $display({"%0t:          actual   k=%0d p=%0d x=%0d y=%0d",
                                  " l=%0d d=%0d last=%0d"},
                                 $time, seg.out_kind, seg.out_power, seg.point_x,
                                 seg.point_y, seg.out_line, seg.duration_ms, seg.last);
                        errors++;
                    end
                end
            end
            if (hold_left > 0) begin
                hold_left--;
                seg.ready <= 0;
            end else if (!hold_done && got >= 60) begin
                hold_done = 1;
                hold_left = 1500;
                seg.ready <= 0;
            end else begin
                seg.ready <= (sent >= 180 && sent < 230) || $urandom_range(99) >= 31;
            end
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        if ((cmd.valid && cmd.ready) || (seg.valid && seg.ready) || !i_rst_n) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("move_trapezoid_segment_planner_unit_tb failed");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    task automatic add_cmd(logic [1:0] k, logic [6:0] p, longint tx, longint ty,
                           logic [15:0] ln, logic [15:0] wt, bit dr = 0);
        t_cmd c;
        c.kind = k; c.power = p; c.tx = tx[COORD_BITS-1:0]; c.ty = ty[COORD_BITS-1:0];
        c.line = ln; c.wait_ms = wt; c.drain = dr;
        if (k == KIND_MOVE) begin
            gen_px = c.tx; gen_py = c.ty;
        end
        pending_cmds.push_back(c);
    endtask

    function automatic longint step_from(longint p, longint d);
        if (p + d > 1048575 || p + d < -1048576) return p - d;
        return p + d;
    endfunction

    task automatic add_random(bit dr);
        longint d1, d2;
        int r;
        r = $urandom_range(9);
        d1 = longint'($urandom_range(2000)) - 1000;
        d2 = longint'($urandom_range(2000)) - 1000;
        if ($urandom_range(99) < 30) begin
            add_cmd($urandom_range(3) == 2 ? KIND_OTHER : 2'($urandom_range(3)),
                    7'($urandom), $signed(21'($urandom)), $signed(21'($urandom)),
                    16'($urandom), 16'($urandom), dr);
        end else if (r == 0) begin
            add_cmd(KIND_MOVE, 7'($urandom), gen_px, gen_py, 16'($urandom), 16'($urandom), dr);
        end else if (r == 1) begin
            add_cmd(KIND_MOVE, 7'($urandom), step_from(gen_px, d1), gen_py,
                    16'($urandom), 16'($urandom), dr);
        end else if (r == 2) begin
            add_cmd(KIND_MOVE, 7'($urandom), gen_px, step_from(gen_py, d2),
                    16'($urandom), 16'($urandom), dr);
        end else if (r == 3) begin
            add_cmd(KIND_MOVE, 7'($urandom), $signed(21'($urandom)), $signed(21'($urandom)),
                    16'($urandom), 16'($urandom), dr);
        end else begin
            add_cmd(KIND_MOVE, 7'($urandom), step_from(gen_px, d1 * (r - 3)),
                    step_from(gen_py, d2 * (r - 3)), 16'($urandom), 16'($urandom), dr);
        end
    endtask

    task automatic wait_idle();
        while (pending_cmds.size() != 0 || cmd.valid || expected_segs.size() != 0)
            @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    task automatic write_reg(logic idx, logic [ACCEL_BITS-1:0] val);
        @(posedge i_clk);
        cfg.we <= 1; cfg.idx <= idx; cfg.data <= val;
        @(posedge i_clk);
        cfg.we <= 0;
        if (idx == CFG_MAX_ACCEL) model_accel = val;
        else model_speed = val[SPEED_BITS-1:0];
    endtask

    initial begin
        logic [ACCEL_BITS-1:0] accels [5] = '{20'd1, 20'd1048575, 20'd0, 20'd3000, 20'd10000};
        logic [ACCEL_BITS-1:0] speeds [5] = '{20'd65535, 20'd1, 20'd0, 20'd200, 20'd500};
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1;
        // directed: pass-through kinds, extremes, zero length, axis and diagonal moves
        add_cmd(KIND_HOME, 0, 0, 0, 0, 0);
        add_cmd(KIND_POWER, 100, -1048576, 1048575, 65535, 65535);
        add_cmd(KIND_OTHER, 127, 1048575, -1048576, 1, 12);
        add_cmd(KIND_MOVE, 50, 0, 0, 2, 9);
        add_cmd(KIND_MOVE, 127, 1048575, 0, 3, 0);
        add_cmd(KIND_MOVE, 0, -1048576, -1048576, 65535, 0);
        add_cmd(KIND_MOVE, 10, -1048576, 1048575, 4, 0);
        add_cmd(KIND_MOVE, 10, -1048575, 1048574, 5, 0);
        add_cmd(KIND_MOVE, 10, -1048575, 1048500, 6, 0);
        add_cmd(KIND_MOVE, 10, 0, 0, 7, 0);
        add_cmd(KIND_MOVE, 10, 1, 1, 8, 0);
        add_cmd(KIND_MOVE, 10, -3, 1, 9, 0);
        add_cmd(KIND_MOVE, 10, -3, -100, 10, 0);
        add_cmd(KIND_MOVE, 10, 500, 400, 11, 0);
        add_cmd(KIND_POWER, 33, 7, 7, 12, 65535);
        add_cmd(KIND_MOVE, 10, 500, 400, 13, 0);
        for (int i = 0; i < 40; i++) add_random(i == 30);
        wait_idle();
        for (int ph = 0; ph < 5; ph++) begin
            write_reg(CFG_MAX_ACCEL, accels[ph]);
            write_reg(CFG_MAX_SPEED, speeds[ph]);
            for (int i = 0; i < 44; i++) add_random(ph == 1 && i == 20);
            wait_idle();
        end
        repeat (50) @(posedge i_clk);
        if (errors == 0 && expected_segs.size() == 0) begin
            $display("move_trapezoid_segment_planner_unit_tb passed");
        end else begin
            $display("move_trapezoid_segment_planner_unit_tb failed");
        end
        $finish;
    end
endmodule

[sim.f]
src/mtsp_pkg.sv
src/mtsp_in_if.sv
src/mtsp_out_if.sv
src/mtsp_alu.sv
src/move_trapezoid_segment_planner_unit.sv
tb/move_trapezoid_segment_planner_unit_tb_if.sv
tb/move_trapezoid_segment_planner_unit_tb.sv
